// ===== sv/plb_pkg.sv =====
// Package for the panic code LED blinker.
// Holds the sequencer phase type, the fixed blink timings and the register indexes.
// No dependencies.
package plb_pkg;

    localparam int unsigned CodeW     = 32;
    localparam int unsigned UnitsW    = 5;
    localparam int unsigned BlinksW   = 5;
    localparam int unsigned TickW     = 16;
    localparam int unsigned RepeatW   = 2;
    localparam int unsigned CodeIdxW  = 2;
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [UnitsW-1:0]    ShortUnits = 5'd6;
    localparam logic [UnitsW-1:0]    GapUnits   = 5'd12;
    localparam logic [UnitsW-1:0]    PauseUnits = 5'd30;
    localparam logic [CodeIdxW-1:0]  NumCodes   = 2'd3;
    localparam logic [TickW-1:0]     TicksReset = 16'd1000;

    localparam logic [CfgIndexW-1:0] CfgTicksPerUnit = 2'd0;
    localparam logic [CfgIndexW-1:0] CfgLedActiveLow = 2'd1;

    localparam logic KindTick  = 1'b0;
    localparam logic KindStart = 1'b1;

    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_LONG_ON   = 8'b0000_0010,
        PH_LONG_OFF  = 8'b0000_0100,
        PH_SHORT_ON  = 8'b0000_1000,
        PH_SHORT_OFF = 8'b0001_0000,
        PH_GAP       = 8'b0010_0000,
        PH_PAUSE     = 8'b0100_0000,
        PH_DONE      = 8'b1000_0000
    } t_phase;

endpackage

// ===== sv/panic_code_led_blinker.sv =====
// Top level of the panic code LED blinker: sequencer state, code latches and result register.
// Depends on plb_pkg.
//
// A start beat in the idle phase latches three 32-bit codes and starts the blink sequence; each
// tick beat while running advances the tick counter, which steps the unit counter down once per
// ticks-per-unit ticks. Each input beat yields one result beat, taken from the state after that
// beat. The next state is worked out combinationally from the state registers, the result sits in
// an output register, and input beats are accepted every cycle unless a waiting result is stalled.
module panic_code_led_blinker #(
    parameter int unsigned REPEAT_COUNT = 3,
    parameter int unsigned LONG_UNITS   = 30
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [plb_pkg::CfgIndexW-1:0]     i_cfg_index,
    input  logic [plb_pkg::CfgDataW-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [plb_pkg::CodeW-1:0]         i_panic_type,
    input  logic [plb_pkg::CodeW-1:0]         i_reason,
    input  logic [plb_pkg::CodeW-1:0]         i_address,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_led_pin,
    output logic                              o_led_lit,
    output logic                              o_busy_res,
    output logic                              o_reset_request
);
    import plb_pkg::*;

    localparam logic [UnitsW-1:0]  LongUnits   = UnitsW'(LONG_UNITS);
    localparam logic [RepeatW-1:0] RepeatCount = RepeatW'(REPEAT_COUNT);

    logic [TickW-1:0]    r_ticks_per_unit;
    logic                r_led_active_low;

    t_phase              r_phase, n_phase;
    logic [RepeatW-1:0]  r_repeats_left, n_repeats_left;
    logic [CodeIdxW-1:0] r_code_index, n_code_index;
    logic [CodeW-1:0]    r_codes [NumCodes];
    logic [CodeW-1:0]    r_shifting_code, n_shifting_code;
    logic [BlinksW-1:0]  r_blinks_left, n_blinks_left;
    logic [UnitsW-1:0]   r_units_left, n_units_left;
    logic [TickW-1:0]    r_tick_count, n_tick_count;
    logic                r_reset_pending, n_reset_pending;

    logic                r_out_valid;
    logic                r_led_pin, r_led_lit, r_busy_res, r_reset_request;

    logic                in_accept;
    logic                latch_codes;
    logic                busy;
    logic                n_busy;
    logic                n_lit;
    logic [TickW-1:0]    tpu;
    logic [TickW-1:0]    tick_inc;
    logic [UnitsW-1:0]   units_dec;
    logic [BlinksW-1:0]  blinks_dec;
    logic [CodeIdxW-1:0] idx_inc;
    logic [RepeatW-1:0]  rep_dec;
    logic [CodeW-1:0]    sel_code;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign busy       = (r_phase != PH_IDLE) && (r_phase != PH_DONE);
    assign tpu        = (r_ticks_per_unit == '0) ? TickW'(1) : r_ticks_per_unit;
    assign tick_inc   = r_tick_count + TickW'(1);
    assign units_dec  = (r_units_left != '0) ? r_units_left - UnitsW'(1) : '0;

    always_comb begin
        n_phase         = r_phase;
        n_repeats_left  = r_repeats_left;
        n_code_index    = r_code_index;
        n_shifting_code = r_shifting_code;
        n_blinks_left   = r_blinks_left;
        n_units_left    = r_units_left;
        n_tick_count    = r_tick_count;
        n_reset_pending = r_reset_pending;
        latch_codes     = 1'b0;
        blinks_dec      = '0;
        idx_inc         = '0;
        rep_dec         = '0;
        sel_code        = '0;

        if (i_kind == KindStart) begin
            if (r_phase == PH_IDLE) begin
                latch_codes    = 1'b1;
                n_repeats_left = RepeatCount;
                n_code_index   = '0;
                n_phase        = PH_LONG_ON;
                n_units_left   = LongUnits;
                n_tick_count   = '0;
            end
        end else if (busy) begin
            n_tick_count = tick_inc;
            if (tick_inc >= tpu) begin
                n_tick_count = '0;
                n_units_left = units_dec;
                if (units_dec == '0) begin
                    case (r_phase)
                        PH_LONG_ON: begin
                            n_phase      = PH_LONG_OFF;
                            n_units_left = LongUnits;
                        end
                        PH_LONG_OFF: begin
                            n_code_index    = '0;
                            n_shifting_code = r_codes[0];
                            n_blinks_left   = BlinksW'(r_codes[0][3:0]) + BlinksW'(1);
                            n_phase         = PH_SHORT_ON;
                            n_units_left    = ShortUnits;
                        end
                        PH_SHORT_ON: begin
                            n_phase      = PH_SHORT_OFF;
                            n_units_left = ShortUnits;
                        end
                        PH_SHORT_OFF: begin
                            blinks_dec    = (r_blinks_left != '0) ?
                                            r_blinks_left - BlinksW'(1) : '0;
                            n_blinks_left = blinks_dec;
                            if (blinks_dec != '0) begin
                                n_phase      = PH_SHORT_ON;
                                n_units_left = ShortUnits;
                            end else begin
                                n_shifting_code = r_shifting_code >> 4;
                                n_phase         = PH_GAP;
                                n_units_left    = GapUnits;
                            end
                        end
                        PH_GAP: begin
                            if (r_shifting_code != '0) begin
                                n_blinks_left = BlinksW'(r_shifting_code[3:0]) + BlinksW'(1);
                                n_phase       = PH_SHORT_ON;
                                n_units_left  = ShortUnits;
                            end else begin
                                n_phase      = PH_PAUSE;
                                n_units_left = PauseUnits;
                            end
                        end
                        PH_PAUSE: begin
                            idx_inc      = r_code_index + CodeIdxW'(1);
                            n_code_index = idx_inc;
                            if (idx_inc < NumCodes) begin
                                sel_code        = r_codes[idx_inc];
                                n_shifting_code = sel_code;
                                n_blinks_left   = BlinksW'(sel_code[3:0]) + BlinksW'(1);
                                n_phase         = PH_SHORT_ON;
                                n_units_left    = ShortUnits;
                            end else begin
                                rep_dec        = (r_repeats_left != '0) ?
                                                 r_repeats_left - RepeatW'(1) : '0;
                                n_repeats_left = rep_dec;
                                if (rep_dec != '0) begin
                                    n_phase      = PH_LONG_ON;
                                    n_units_left = LongUnits;
                                end else begin
                                    n_phase         = PH_DONE;
                                    n_units_left    = '0;
                                    n_reset_pending = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        n_lit  = (n_phase == PH_LONG_ON) || (n_phase == PH_SHORT_ON);
        n_busy = (n_phase != PH_IDLE) && (n_phase != PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_unit <= TicksReset;
            r_led_active_low <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgTicksPerUnit: r_ticks_per_unit <= i_cfg_data;
                CfgLedActiveLow: r_led_active_low <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_repeats_left  <= '0;
            r_code_index    <= '0;
            r_shifting_code <= '0;
            r_blinks_left   <= '0;
            r_units_left    <= '0;
            r_tick_count    <= '0;
            r_reset_pending <= 1'b0;
            r_codes[0]      <= '0;
            r_codes[1]      <= '0;
            r_codes[2]      <= '0;
        end else if (in_accept) begin
            r_phase         <= n_phase;
            r_repeats_left  <= n_repeats_left;
            r_code_index    <= n_code_index;
            r_shifting_code <= n_shifting_code;
            r_blinks_left   <= n_blinks_left;
            r_units_left    <= n_units_left;
            r_tick_count    <= n_tick_count;
            r_reset_pending <= n_reset_pending;
            if (latch_codes) begin
                r_codes[0] <= i_panic_type;
                r_codes[1] <= i_reason;
                r_codes[2] <= i_address;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_led_lit       <= n_lit;
            r_led_pin       <= n_lit ^ r_led_active_low;
            r_busy_res      <= n_busy;
            r_reset_request <= n_reset_pending;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_led_pin       = r_led_pin;
    assign o_led_lit       = r_led_lit;
    assign o_busy_res      = r_busy_res;
    assign o_reset_request = r_reset_request;

    // The unit counter is reloaded whenever it would expire in a running phase.
    a_units_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_units_left != '0))
        else $error("unit counter empty while the sequence runs");

    a_blinks_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_SHORT_ON) || (r_phase == PH_SHORT_OFF)) |-> (r_blinks_left != '0))
        else $error("short blink phase with no blinks left");

    a_reset_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reset_pending |=> (r_reset_pending && (r_phase == PH_DONE)))
        else $error("reset request dropped or sequence restarted");

    a_lit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_led_lit) |-> r_busy_res)
        else $error("LED lit in a result while the sequence is not running");

endmodule
